@@ design/bta_pkg.sv @@
// types and constants shared by the block table heap allocator
package bta_pkg;

	localparam int TABLE_DEPTH = 1024;
	// block size is a power of two, so block arithmetic is shifts and masks
	localparam int BLOCK_BYTES = 4096;
	localparam int BLK_SHIFT   = $clog2(BLOCK_BYTES);

	localparam int IDX_W    = $clog2(TABLE_DEPTH);
	localparam int CNT_W    = $clog2(TABLE_DEPTH + 1);
	localparam int ADDR_W   = 32;
	localparam int BYTES_W  = 32;
	localparam int BLOCKS_W = 11;
	localparam int STATUS_W = 2;
	localparam int ENTRY_W  = 3;
	localparam int CFG_IDX_W = 1;

	localparam logic [BLOCKS_W-1:0] BLOCKS_RESET = BLOCKS_W'(1024);

	// entry bit positions
	localparam int ENT_TAKEN = 0;
	localparam int ENT_FIRST = 1;
	localparam int ENT_NEXT  = 2;

	localparam logic [0:0] OP_ALLOC = 1'b0;
	localparam logic [0:0] OP_FREE  = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOMEM   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BADFREE = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_BASE   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCKS = 1'd1;

	typedef logic [IDX_W-1:0]   idx_t;
	typedef logic [CNT_W-1:0]   cnt_t;
	typedef logic [ENTRY_W-1:0] entry_t;

	typedef struct packed {
		logic   we;
		idx_t   waddr;
		entry_t wdata;
		idx_t   raddr;
	} ram_req_t;

	typedef struct packed {
		logic [ADDR_W-1:0] base;
		cnt_t              limit;
	} heap_cfg_t;

endpackage

@@ design/bta_if.sv @@
// request, response and register write channels

interface bta_req_if;
	logic                         valid;
	logic                         ready;
	logic [0:0]                   op;
	logic [bta_pkg::BYTES_W-1:0]  request_bytes;
	logic [bta_pkg::ADDR_W-1:0]   free_address;
	modport source (output valid, op, request_bytes, free_address, input ready);
	modport sink (input valid, op, request_bytes, free_address, output ready);
endinterface

interface bta_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [bta_pkg::ADDR_W-1:0]   granted_address;
	logic [bta_pkg::STATUS_W-1:0] status;
	modport source (output valid, granted_address, status, input ready);
	modport sink (input valid, granted_address, status, output ready);
endinterface

interface bta_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [bta_pkg::CFG_IDX_W-1:0] index;
	logic [31:0]                   data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ design/bta_ram.sv @@
// block table memory, one write and one registered read port
module bta_ram (
	input  logic              clk,
	input  bta_pkg::ram_req_t req,
	output bta_pkg::entry_t   rdata
);

	bta_pkg::entry_t mem [bta_pkg::TABLE_DEPTH];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		rdata <= mem[req.raddr];
	end

endmodule

@@ design/bta_ctrl.sv @@
// request sequencer: clearing pass, first-fit scan, run marking and free walk
module bta_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  bta_pkg::heap_cfg_t cfg,
	bta_req_if.sink            req,
	bta_rsp_if.source          rsp,
	output bta_pkg::ram_req_t  ram_req,
	input  bta_pkg::entry_t    ram_rdata
);

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_SCAN  = 3'd2;
	localparam logic [2:0] S_FILL  = 3'd3;
	localparam logic [2:0] S_WALK  = 3'd4;
	localparam logic [2:0] S_RESP  = 3'd5;

	logic [2:0] state_q;
	bta_pkg::cnt_t issue_q;
	logic          vld_s1;
	bta_pkg::idx_t idx_s1;
	bta_pkg::cnt_t want_q;
	bta_pkg::cnt_t run_q;
	bta_pkg::idx_t start_q;
	bta_pkg::cnt_t fill_q;
	logic [bta_pkg::ADDR_W-1:0]   res_addr_q;
	logic [bta_pkg::STATUS_W-1:0] res_st_q;
	logic                         rsp_valid_q;
	logic [bta_pkg::ADDR_W-1:0]   rsp_addr_q;
	logic [bta_pkg::STATUS_W-1:0] rsp_st_q;

	// request decode
	logic [bta_pkg::BYTES_W:0] want_w;
	logic [bta_pkg::ADDR_W-1:0] offset;
	logic [bta_pkg::ADDR_W-1:0] blk;
	logic                       alloc_bad;
	logic                       free_bad;

	logic          can_issue;
	bta_pkg::cnt_t run_inc;
	bta_pkg::cnt_t fill_inc;
	bta_pkg::cnt_t idx_inc;
	logic          walk_end;
	logic          rsp_free;

	assign want_w = ((bta_pkg::BYTES_W + 1)'(req.request_bytes)
		+ (bta_pkg::BYTES_W + 1)'(bta_pkg::BLOCK_BYTES - 1)) >> bta_pkg::BLK_SHIFT;
	assign alloc_bad = (want_w == '0) || (want_w > (bta_pkg::BYTES_W + 1)'(cfg.limit));
	assign offset = req.free_address - cfg.base;
	assign blk = offset >> bta_pkg::BLK_SHIFT;
	assign free_bad = (req.free_address < cfg.base)
		|| (offset[bta_pkg::BLK_SHIFT-1:0] != '0)
		|| (blk >= bta_pkg::ADDR_W'(cfg.limit));

	assign can_issue = issue_q < cfg.limit;
	assign run_inc = run_q + 1'b1;
	assign fill_inc = fill_q + 1'b1;
	assign idx_inc = bta_pkg::CNT_W'(idx_s1) + 1'b1;
	assign walk_end = !ram_rdata[bta_pkg::ENT_NEXT] || (idx_inc >= cfg.limit);
	assign rsp_free = !rsp_valid_q || rsp.ready;

	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = rsp_valid_q;
	assign rsp.granted_address = rsp_addr_q;
	assign rsp.status = rsp_st_q;

	always_comb begin
		ram_req.we = 1'b0;
		ram_req.waddr = issue_q[bta_pkg::IDX_W-1:0];
		ram_req.wdata = '0;
		ram_req.raddr = issue_q[bta_pkg::IDX_W-1:0];
		unique case (state_q)
			S_CLEAR: begin
				ram_req.we = 1'b1;
			end
			S_FILL: begin
				ram_req.we = 1'b1;
				ram_req.waddr = start_q + fill_q[bta_pkg::IDX_W-1:0];
				ram_req.wdata[bta_pkg::ENT_TAKEN] = 1'b1;
				ram_req.wdata[bta_pkg::ENT_FIRST] = (fill_q == '0);
				ram_req.wdata[bta_pkg::ENT_NEXT] = (fill_inc < want_q);
			end
			S_WALK: begin
				// clear the entry in hand while the next one is read
				ram_req.we = vld_s1;
				ram_req.waddr = idx_s1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			issue_q <= '0;
			vld_s1 <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					issue_q <= issue_q + 1'b1;
					if (issue_q == bta_pkg::CNT_W'(bta_pkg::TABLE_DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					vld_s1 <= 1'b0;
					run_q <= '0;
					fill_q <= '0;
					res_addr_q <= '0;
					if (req.valid) begin
						if (req.op == bta_pkg::OP_ALLOC) begin
							want_q <= bta_pkg::CNT_W'(want_w);
							issue_q <= '0;
							if (alloc_bad) begin
								res_st_q <= bta_pkg::ST_NOMEM;
								state_q <= S_RESP;
							end else begin
								state_q <= S_SCAN;
							end
						end else begin
							issue_q <= bta_pkg::CNT_W'(blk);
							if (free_bad) begin
								res_st_q <= bta_pkg::ST_BADFREE;
								state_q <= S_RESP;
							end else begin
								res_st_q <= bta_pkg::ST_OK;
								state_q <= S_WALK;
							end
						end
					end
				end
				S_SCAN: begin
					vld_s1 <= can_issue;
					idx_s1 <= issue_q[bta_pkg::IDX_W-1:0];
					if (can_issue) begin
						issue_q <= issue_q + 1'b1;
					end
					if (vld_s1) begin
						if (ram_rdata[bta_pkg::ENT_TAKEN]) begin
							run_q <= '0;
						end else begin
							if (run_q == '0) begin
								start_q <= idx_s1;
							end
							run_q <= run_inc;
							if (run_inc == want_q) begin
								vld_s1 <= 1'b0;
								state_q <= S_FILL;
							end
						end
					end else if (!can_issue) begin
						res_st_q <= bta_pkg::ST_NOMEM;
						state_q <= S_RESP;
					end
				end
				S_FILL: begin
					fill_q <= fill_inc;
					if (fill_inc == want_q) begin
						res_addr_q <= cfg.base
							+ (bta_pkg::ADDR_W'(start_q) << bta_pkg::BLK_SHIFT);
						res_st_q <= bta_pkg::ST_OK;
						state_q <= S_RESP;
					end
				end
				S_WALK: begin
					vld_s1 <= can_issue;
					idx_s1 <= issue_q[bta_pkg::IDX_W-1:0];
					if (can_issue) begin
						issue_q <= issue_q + 1'b1;
					end
					if (vld_s1 && walk_end) begin
						vld_s1 <= 1'b0;
						state_q <= S_RESP;
					end
				end
				S_RESP: begin
					if (rsp_free) begin
						rsp_valid_q <= 1'b1;
						rsp_addr_q <= res_addr_q;
						rsp_st_q <= res_st_q;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

@@ design/block_table_heap_allocator_unit.sv @@
// First-fit heap allocator over a block table of 1024 entries, 4096-byte blocks. After reset
// the table is cleared to free by a pass over every entry, during which no request is taken
// (register writes are). The block then handles one request at a time. An allocate scans the
// table from entry 0, one entry per cycle through the table memory's read port, and then marks
// the run one entry per cycle on the write port; a size that is zero or too large is answered
// without a scan. A free walks the has-next chain, one entry per cycle, and clears it; a bad
// address is answered without a walk. A finished response sits in an output register, so the
// next request can be taken before the previous response has been collected. Registers:
// 0 base_address, 1 heap size in blocks.
module block_table_heap_allocator_unit (
	input  logic      clk,
	input  logic      arst_n,
	bta_cfg_if.sink   cfg,
	bta_req_if.sink   req,
	bta_rsp_if.source rsp
);

	logic [bta_pkg::ADDR_W-1:0]   base_q;
	logic [bta_pkg::BLOCKS_W-1:0] blocks_q;
	bta_pkg::heap_cfg_t           heap_cfg;
	bta_pkg::ram_req_t            ram_req;
	bta_pkg::entry_t              ram_rdata;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			blocks_q <= bta_pkg::BLOCKS_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				bta_pkg::REG_BASE: base_q <= cfg.data;
				bta_pkg::REG_BLOCKS: blocks_q <= cfg.data[bta_pkg::BLOCKS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// heap size in effect is capped at the table depth
	always_comb begin
		heap_cfg.base = base_q;
		if (32'(blocks_q) > 32'(bta_pkg::TABLE_DEPTH)) begin
			heap_cfg.limit = bta_pkg::CNT_W'(bta_pkg::TABLE_DEPTH);
		end else begin
			heap_cfg.limit = bta_pkg::CNT_W'(blocks_q);
		end
	end

	bta_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (heap_cfg),
		.req       (req),
		.rsp       (rsp),
		.ram_req   (ram_req),
		.ram_rdata (ram_rdata)
	);

	bta_ram u_ram (
		.clk   (clk),
		.req   (ram_req),
		.rdata (ram_rdata)
	);

endmodule

@@ test/block_table_heap_allocator_unit_tb.sv @@
`timescale 1ns / 1ps
// first-fit block table allocator: directed table then random phases checked against a predictor
module block_table_heap_allocator_unit_tb;
	import bta_pkg::*;

	localparam int LONG_HOLD     = 400;
	localparam int SETTLE_CYCLES = 2 * TABLE_DEPTH + 64;
	localparam int REPORT_LIMIT  = 10;
	localparam int N_PHASES      = 8;

	typedef struct packed {
		logic [ADDR_W-1:0]   addr;
		logic [STATUS_W-1:0] status;
	} grant_t;

	typedef struct packed {
		bit     pinned;
		grant_t g;
	} pin_t;

	// value is the byte count, the free address or the register data, by row kind
	typedef struct packed {
		bit                    is_reg;
		logic [CFG_IDX_W-1:0]  reg_idx;
		logic [0:0]            op;
		logic [31:0]           value;
		bit                    pinned;
		logic [ADDR_W-1:0]     want_addr;
		logic [STATUS_W-1:0]   want_status;
	} step_t;

	step_t plan [30] = '{
		'{1'b0, REG_BASE,   OP_ALLOC, 32'h0000_0000, 1'b1, 32'h0000_0000, ST_NOMEM},
		'{1'b0, REG_BASE,   OP_ALLOC, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, ST_NOMEM},
		'{1'b0, REG_BASE,   OP_ALLOC, 32'h0000_0001, 1'b1, 32'h0000_0000, ST_OK},
		'{1'b0, REG_BASE,   OP_ALLOC, 32'h0000_1000, 1'b1, 32'h0000_1000, ST_OK},
		'{1'b0, REG_BASE,   OP_ALLOC, 32'h0000_1001, 1'b1, 32'h0000_2000, ST_OK},
		'{1'b0, REG_BASE,   OP_FREE,  32'h0000_2001, 1'b1, 32'h0000_0000, ST_BADFREE},
		'{1'b0, REG_BASE,   OP_FREE,  32'h0040_0000, 1'b1, 32'h0000_0000, ST_BADFREE},
		'{1'b0, REG_BASE,   OP_FREE,  32'hFFFF_FFFF, 1'b1, 32'h0000_0000, ST_BADFREE},
		// non-first block, then a block that is already free
		'{1'b0, REG_BASE,   OP_FREE,  32'h0000_3000, 1'b0, 32'h0, ST_OK},
		'{1'b0, REG_BASE,   OP_FREE,  32'h0000_5000, 1'b0, 32'h0, ST_OK},
		'{1'b0, REG_BASE,   OP_FREE,  32'h0000_1000, 1'b0, 32'h0, ST_OK},
		'{1'b0, REG_BASE,   OP_ALLOC, 32'h0040_0000, 1'b0, 32'h0, ST_OK},
		'{1'b0, REG_BASE,   OP_FREE,  32'h0000_0000, 1'b0, 32'h0, ST_OK},
		'{1'b0, REG_BASE,   OP_FREE,  32'h0000_2000, 1'b0, 32'h0, ST_OK},
		// whole table in one run, then full, then a chain walked to the table end
		'{1'b0, REG_BASE,   OP_ALLOC, 32'h0040_0000, 1'b0, 32'h0, ST_OK},
		'{1'b0, REG_BASE,   OP_ALLOC, 32'h0000_0001, 1'b0, 32'h0, ST_OK},
		'{1'b0, REG_BASE,   OP_FREE,  32'h0000_0000, 1'b0, 32'h0, ST_OK},
		'{1'b0, REG_BASE,   OP_ALLOC, 32'h8000_0000, 1'b1, 32'h0000_0000, ST_NOMEM},
		// empty heap
		'{1'b1, REG_BLOCKS, OP_ALLOC, 32'd0,         1'b0, 32'h0, ST_OK},
		'{1'b0, REG_BASE,   OP_ALLOC, 32'h0000_0001, 1'b1, 32'h0000_0000, ST_NOMEM},
		'{1'b0, REG_BASE,   OP_FREE,  32'h0000_0000, 1'b1, 32'h0000_0000, ST_BADFREE},
		// heap at the top of the address space, grant wraps to address zero
		'{1'b1, REG_BASE,   OP_ALLOC, 32'hFFFF_F000, 1'b0, 32'h0, ST_OK},
		'{1'b1, REG_BLOCKS, OP_ALLOC, 32'd4,         1'b0, 32'h0, ST_OK},
		'{1'b0, REG_BASE,   OP_ALLOC, 32'h0000_1000, 1'b1, 32'hFFFF_F000, ST_OK},
		'{1'b0, REG_BASE,   OP_ALLOC, 32'h0000_1000, 1'b1, 32'h0000_0000, ST_OK},
		// only two free blocks left at the table end
		'{1'b0, REG_BASE,   OP_ALLOC, 32'h0000_3000, 1'b0, 32'h0, ST_OK},
		'{1'b0, REG_BASE,   OP_FREE,  32'hFFFF_EFFF, 1'b1, 32'h0000_0000, ST_BADFREE},
		// unaligned base
		'{1'b1, REG_BASE,   OP_ALLOC, 32'h0000_0123, 1'b0, 32'h0, ST_OK},
		'{1'b0, REG_BASE,   OP_FREE,  32'h0000_0123, 1'b0, 32'h0, ST_OK},
		'{1'b0, REG_BASE,   OP_ALLOC, 32'h0000_0001, 1'b0, 32'h0, ST_OK}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	bta_cfg_if cfg ();
	bta_req_if req ();
	bta_rsp_if rsp ();

	block_table_heap_allocator_unit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.req    (req),
		.rsp    (rsp)
	);

	// predictor state
	entry_t              block_map [TABLE_DEPTH];
	logic [ADDR_W-1:0]   heap_base;
	logic [BLOCKS_W-1:0] heap_blocks;

	grant_t pending_grants [$];
	pin_t   pinned_grants [$];
	int     fail_count = 0;
	int     burst_left = 0;
	int     hold_asked = 0;
	int     hold_served = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#100_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	function automatic int unsigned covered();
		return (heap_blocks > TABLE_DEPTH) ? TABLE_DEPTH : heap_blocks;
	endfunction

	function automatic grant_t predict_grant(logic [0:0] op, logic [31:0] bytes,
			logic [ADDR_W-1:0] addr);
		grant_t            g;
		int unsigned       lim;
		longint unsigned   want;
		int unsigned       run;
		int unsigned       start;
		bit                found;
		entry_t            e;
		logic [ADDR_W-1:0] offset;
		g.addr = '0;
		lim = covered();
		if (op == OP_ALLOC) begin
			g.status = ST_NOMEM;
			want = ({32'd0, bytes} + 64'(BLOCK_BYTES - 1)) / 64'(BLOCK_BYTES);
			run = 0;
			start = 0;
			found = 1'b0;
			if (want != 0 && want <= lim) begin
				for (int unsigned i = 0; i < lim; i++) begin
					if (block_map[i][ENT_TAKEN]) begin
						run = 0;
					end else begin
						if (run == 0)
							start = i;
						run++;
						if (run == want) begin
							found = 1'b1;
							break;
						end
					end
				end
			end
			if (found) begin
				for (int unsigned i = 0; i < run; i++) begin
					e = '0;
					e[ENT_TAKEN] = 1'b1;
					e[ENT_FIRST] = (i == 0);
					e[ENT_NEXT] = (i + 1 < run);
					block_map[start + i] = e;
				end
				g.addr = heap_base + ADDR_W'(start * BLOCK_BYTES);
				g.status = ST_OK;
			end
		end else begin
			g.status = ST_BADFREE;
			if (addr >= heap_base) begin
				offset = addr - heap_base;
				if (offset % BLOCK_BYTES == 0 && offset / BLOCK_BYTES < lim) begin
					for (int unsigned i = offset / BLOCK_BYTES; i < lim; i++) begin
						e = block_map[i];
						block_map[i] = '0;
						if (!e[ENT_NEXT])
							break;
					end
					g.status = ST_OK;
				end
			end
		end
		return g;
	endfunction

	always @(posedge clk) begin
		if (arst_n && cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_BASE: heap_base = cfg.data;
				REG_BLOCKS: heap_blocks = cfg.data[BLOCKS_W-1:0];
			endcase
		end
	end

	always @(posedge clk) begin
		grant_t g;
		pin_t   p;
		if (arst_n && req.valid && req.ready) begin
			g = predict_grant(req.op, req.request_bytes, req.free_address);
			p = pinned_grants.pop_front();
			if (p.pinned)
				g = p.g;
			pending_grants.push_back(g);
		end
	end

	always @(posedge clk) begin
		grant_t w;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (pending_grants.size() == 0) begin
				fail_count++;
				if (fail_count <= REPORT_LIMIT)
					$display("unexpected response: addr %h status %0d",
						rsp.granted_address, rsp.status);
			end else begin
				w = pending_grants.pop_front();
				if (rsp.granted_address !== w.addr || rsp.status !== w.status) begin
					fail_count++;
					if (fail_count <= REPORT_LIMIT)
						$display("grant mismatch: expected addr %h status %0d, got addr %h status %0d",
							w.addr, w.status, rsp.granted_address, rsp.status);
				end
			end
		end
	end

	// receiver: stall pattern changes after a random span, long hold on demand
	initial begin
		int mode;
		int span;
		int tick;
		rsp.ready = 1'b0;
		tick = 0;
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(16, 160);
			repeat (span) begin
				@(negedge clk);
				tick++;
				if (hold_served != hold_asked) begin
					rsp.ready <= 1'b0;
					repeat (LONG_HOLD - 1) @(negedge clk);
					hold_served++;
				end else begin
					case (mode)
						0: rsp.ready <= 1'b1;
						1: rsp.ready <= ($urandom_range(0, 3) != 0);
						2: rsp.ready <= (tick % 5 != 0);
						default: rsp.ready <= $urandom_range(0, 1);
					endcase
				end
			end
		end
	end

	task automatic send_request(input logic [0:0] op, input logic [31:0] bytes,
			input logic [ADDR_W-1:0] addr, input pin_t pin);
		int gap;
		@(negedge clk);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap != 0) begin
				req.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		pinned_grants.push_back(pin);
		req.valid <= 1'b1;
		req.op <= op;
		req.request_bytes <= bytes;
		req.free_address <= addr;
		do begin
			@(posedge clk);
		end while (!req.ready);
		burst_left--;
	endtask

	// stop requesting and wait until every grant has come back
	task automatic drain();
		@(negedge clk);
		req.valid <= 1'b0;
		burst_left = 0;
		while (pending_grants.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
		@(negedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= data;
		do begin
			@(posedge clk);
		end while (!cfg.ready);
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	initial begin
		int unsigned         lim;
		int                  k;
		int                  s;
		int                  n_items;
		int                  pick;
		int                  firsts;
		int                  idx;
		logic [ADDR_W-1:0]   base_sel;
		logic [BLOCKS_W-1:0] blocks_sel;
		logic [31:0]         bytes;
		logic [ADDR_W-1:0]   addr;
		logic [0:0]          op;
		pin_t                pin;

		cfg.valid = 1'b0;
		cfg.index = REG_BASE;
		cfg.data = '0;
		req.valid = 1'b0;
		req.op = OP_ALLOC;
		req.request_bytes = '0;
		req.free_address = '0;
		heap_base = '0;
		heap_blocks = BLOCKS_RESET;
		foreach (block_map[i])
			block_map[i] = '0;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (plan[r]) begin
			if (plan[r].is_reg) begin
				drain();
				write_reg(plan[r].reg_idx, plan[r].value);
			end else begin
				pin.pinned = plan[r].pinned;
				pin.g.addr = plan[r].want_addr;
				pin.g.status = plan[r].want_status;
				if (plan[r].op == OP_ALLOC)
					send_request(OP_ALLOC, plan[r].value, $urandom, pin);
				else
					send_request(OP_FREE, $urandom, plan[r].value, pin);
			end
		end

		pin = '0;
		for (int ph = 0; ph < N_PHASES; ph++) begin
			case (ph)
				0: begin
					base_sel = $urandom & ~ADDR_W'(BLOCK_BYTES - 1);
					blocks_sel = 16;
					n_items = 110;
				end
				1: begin
					base_sel = 32'hFFFF_FFFF;
					blocks_sel = 8;
					n_items = 60;
				end
				2: begin
					base_sel = $urandom;
					blocks_sel = 64;
					n_items = 110;
				end
				3: begin
					base_sel = '0;
					blocks_sel = 1024;
					n_items = 100;
				end
				4: begin
					base_sel = $urandom & ~ADDR_W'(BLOCK_BYTES - 1);
					blocks_sel = 1;
					n_items = 50;
				end
				5: begin
					base_sel = 32'hFFFF_F000;
					blocks_sel = 2047;
					n_items = 60;
				end
				6: begin
					base_sel = $urandom;
					blocks_sel = 0;
					n_items = 20;
				end
				default: begin
					// shrink back down, the entries above keep their marks
					base_sel = $urandom & ~ADDR_W'(BLOCK_BYTES - 1);
					blocks_sel = 16;
					n_items = 70;
				end
			endcase
			drain();
			write_reg(REG_BASE, base_sel);
			write_reg(REG_BLOCKS, 32'(blocks_sel));
			// receiver holds off while requests keep coming, so the block backs up
			if (ph == 2)
				hold_asked++;
			for (int it = 0; it < n_items; it++) begin
				if (ph == 0 && it == n_items / 2)
					drain();
				lim = covered();
				if ($urandom_range(0, 1) == 0) begin
					op = OP_ALLOC;
					addr = $urandom;
					s = $urandom_range(0, 99);
					if (s < 75) begin
						k = $urandom_range(1, (lim == 0) ? 1 : ((lim < 4) ? lim : 4));
						bytes = (k - 1) * BLOCK_BYTES + $urandom_range(1, BLOCK_BYTES);
					end else if (s < 88) begin
						bytes = $urandom_range(0, (lim + 1) * BLOCK_BYTES);
					end else if (s < 94) begin
						bytes = '0;
					end else begin
						bytes = $urandom;
					end
				end else begin
					op = OP_FREE;
					bytes = $urandom;
					s = $urandom_range(0, 99);
					firsts = 0;
					for (int unsigned i = 0; i < lim; i++)
						if (block_map[i][ENT_FIRST])
							firsts++;
					if (s < 45 && firsts != 0) begin
						// start of a live run
						pick = $urandom_range(0, firsts - 1);
						idx = 0;
						for (int unsigned i = 0; i < lim; i++) begin
							if (block_map[i][ENT_FIRST]) begin
								if (pick == 0) begin
									idx = i;
									break;
								end
								pick--;
							end
						end
						addr = heap_base + ADDR_W'(idx * BLOCK_BYTES);
					end else if (s < 80) begin
						k = $urandom_range(0, (lim == 0) ? 0 : lim - 1);
						addr = heap_base + ADDR_W'(k * BLOCK_BYTES);
					end else if (s < 90) begin
						k = $urandom_range(0, lim);
						addr = heap_base + ADDR_W'(k * BLOCK_BYTES)
							+ ADDR_W'($urandom_range(1, BLOCK_BYTES - 1));
					end else begin
						addr = $urandom;
					end
				end
				send_request(op, bytes, addr, pin);
			end
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending_grants.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
